[hw/rtl/nfd_pkg.sv]
// ----------------------------------------------------------------------------
// nfd_pkg
// Shared widths, constants and types of the nonuniform derivative peak finder.
// ----------------------------------------------------------------------------
`default_nettype none

package nfd_pkg;

   localparam int VOL_W       = 16;
   localparam int PH_W        = 16;
   localparam int SLOPE_W     = 32;
   localparam int PEAK_IDX_W  = 10;
   localparam int DIFF_W      = 17;
   localparam int MAX_POINTS_DEF = 1024;

   localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = 32'sh8000_0000;

   typedef logic signed [DIFF_W-1:0] diff_type;

   // spacings and pH steps of the three held samples
   typedef struct packed {
      diff_type d10;
      diff_type d21;
      diff_type d20;
      diff_type p10;
      diff_type p21;
   } slope_ops_type;

   typedef struct packed {
      logic                       deriv_valid;
      logic [VOL_W-1:0]           center_volume;
      logic signed [SLOPE_W-1:0]  slope;
      logic                       spacing_fault;
      logic                       curve_done;
      logic [VOL_W-1:0]           peak_volume;
      logic [PEAK_IDX_W-1:0]      peak_index;
      logic                       peak_found;
   } rsp_type;

endpackage

`default_nettype wire

[hw/rtl/nfd_channels_if.sv]
// ----------------------------------------------------------------------------
// nfd channels
// Valid/ready channels for samples in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface nfd_req_if;
   logic                     valid;
   logic                     ready;
   logic [nfd_pkg::VOL_W-1:0] sample_volume;
   logic [nfd_pkg::PH_W-1:0]  sample_ph;
   logic                     end_of_curve;

   modport source (output valid, output sample_volume, output sample_ph,
                   output end_of_curve, input ready);
   modport sink   (input valid, input sample_volume, input sample_ph,
                   input end_of_curve, output ready);
endinterface

interface nfd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              deriv_valid;
   logic [nfd_pkg::VOL_W-1:0]         center_volume;
   logic signed [nfd_pkg::SLOPE_W-1:0] slope;
   logic                              spacing_fault;
   logic                              curve_done;
   logic [nfd_pkg::VOL_W-1:0]         peak_volume;
   logic [nfd_pkg::PEAK_IDX_W-1:0]    peak_index;
   logic                              peak_found;

   modport source (output valid, output deriv_valid, output center_volume,
                   output slope, output spacing_fault, output curve_done,
                   output peak_volume, output peak_index, output peak_found,
                   input ready);
   modport sink   (input valid, input deriv_valid, input center_volume,
                   input slope, input spacing_fault, input curve_done,
                   input peak_volume, input peak_index, input peak_found,
                   output ready);
endinterface

`default_nettype wire

[hw/rtl/nonuniform_derivative_peak_finder.sv]
// ----------------------------------------------------------------------------
// nonuniform_derivative_peak_finder
// Weighted three-point derivative over unevenly spaced titration samples,
// with tracking of the first strictly greatest derivative per curve.
//
//   channel   dir   handshake      beat carries
//   req_chan  in    valid/ready    sample_volume, sample_ph, end_of_curve
//   rsp_chan  out   valid/ready    derivative point and end-of-curve peak
//
// A sample with a derivative point holds off the next accept while the slope
// unit runs six shared multiplies and, unless the quotient overflows, its
// 32-step divider; samples without a point or with zero spacing skip the unit.
// Reset is synchronous and clears history and peak state.
// The output register holds a beat while the sink stalls; a new sample is
// still taken, and its commit waits only if it must write a result.
// ----------------------------------------------------------------------------
`default_nettype none

module nonuniform_derivative_peak_finder #(
   parameter int MAX_POINTS = nfd_pkg::MAX_POINTS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   nfd_req_if.sink      req_chan,
   nfd_rsp_if.source    rsp_chan
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int VW    = nfd_pkg::VOL_W;
   localparam int PW    = nfd_pkg::PH_W;
   localparam int SW    = nfd_pkg::SLOPE_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EVAL   = 2'd1;
   localparam logic [1:0] ST_CALC   = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   localparam logic [1:0] SEEN_FULL = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [VW-1:0]          vol0_ff, vol0_in, vol1_ff, vol1_in;
   logic [PW-1:0]          ph0_ff, ph0_in, ph1_ff, ph1_in;
   logic [1:0]             seen_ff, seen_in;
   logic [VW-1:0]          cur_vol_ff, cur_vol_in;
   logic [PW-1:0]          cur_ph_ff, cur_ph_in;
   logic                   cur_last_ff, cur_last_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic signed [SW-1:0]   best_slope_ff, best_slope_in;
   logic [VW-1:0]          best_vol_ff, best_vol_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   nfd_pkg::rsp_type       rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   nfd_pkg::slope_ops_type ops;
   logic                   have_point;
   logic                   fault;
   logic                   calc_start;
   logic                   calc_done;
   logic signed [SW-1:0]   calc_slope;
   logic signed [SW-1:0]   point_slope;
   logic                   need_rsp;
   logic                   can_commit;
   logic [IDX_W+9:0]       idx_ext;

   assign ops.d10 = $signed({1'b0, vol1_ff}) - $signed({1'b0, vol0_ff});
   assign ops.d21 = $signed({1'b0, cur_vol_ff}) - $signed({1'b0, vol1_ff});
   assign ops.d20 = $signed({1'b0, cur_vol_ff}) - $signed({1'b0, vol0_ff});
   assign ops.p10 = $signed({1'b0, ph1_ff}) - $signed({1'b0, ph0_ff});
   assign ops.p21 = $signed({1'b0, cur_ph_ff}) - $signed({1'b0, ph1_ff});

   assign have_point = seen_ff == SEEN_FULL;
   assign fault      = (ops.d10 == '0) || (ops.d21 == '0) || (ops.d20 == '0);
   assign calc_start = (state_ff == ST_EVAL) && have_point && !fault;

   nfd_slope_unit u_slope (
      .clock (clock),
      .reset (reset),
      .start (calc_start),
      .ops   (ops),
      .done  (calc_done),
      .slope (calc_slope)
   );

   assign point_slope = fault ? ((cur_ph_ff >= ph0_ff) ? nfd_pkg::SLOPE_MAX
                                                       : nfd_pkg::SLOPE_MIN)
                              : calc_slope;
   assign need_rsp    = have_point || cur_last_ff;
   assign can_commit  = !need_rsp || !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      vol0_in       = vol0_ff;
      vol1_in       = vol1_ff;
      ph0_in        = ph0_ff;
      ph1_in        = ph1_ff;
      seen_in       = seen_ff;
      cur_vol_in    = cur_vol_ff;
      cur_ph_in     = cur_ph_ff;
      cur_last_in   = cur_last_ff;
      count_in      = count_ff;
      best_slope_in = best_slope_ff;
      best_vol_in   = best_vol_ff;
      best_idx_in   = best_idx_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      idx_ext       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cur_vol_in  = req_chan.sample_volume;
               cur_ph_in   = req_chan.sample_ph;
               cur_last_in = req_chan.end_of_curve;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = calc_start ? ST_CALC : ST_COMMIT;
         end
         ST_CALC: begin
            if (calc_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (can_commit) begin
               if (have_point && (count_ff < CNT_W'(MAX_POINTS))) begin
                  if ((count_ff == '0) || (point_slope > best_slope_ff)) begin
                     best_slope_in = point_slope;
                     best_vol_in   = vol1_ff;
                     best_idx_in   = count_ff[IDX_W-1:0];
                  end
                  count_in = count_ff + 1'b1;
               end
               // a held beat stays untouched when this sample has no result
               if (need_rsp) begin
                  idx_ext = {10'b0, best_idx_in};
                  rsp_in.deriv_valid   = have_point;
                  rsp_in.center_volume = have_point ? vol1_ff : '0;
                  rsp_in.slope         = have_point ? point_slope : '0;
                  rsp_in.spacing_fault = have_point && fault;
                  rsp_in.curve_done    = cur_last_ff;
                  rsp_in.peak_found    = cur_last_ff && (count_in != '0);
                  rsp_in.peak_volume   = rsp_in.peak_found ? best_vol_in : '0;
                  rsp_in.peak_index    = rsp_in.peak_found ? idx_ext[9:0] : '0;
                  rsp_valid_in = 1'b1;
               end
               if (cur_last_ff) begin
                  // curve closed: start the next one from scratch
                  vol0_in       = '0;
                  vol1_in       = '0;
                  ph0_in        = '0;
                  ph1_in        = '0;
                  seen_in       = '0;
                  count_in      = '0;
                  best_slope_in = '0;
                  best_vol_in   = '0;
                  best_idx_in   = '0;
               end else begin
                  vol0_in = vol1_ff;
                  ph0_in  = ph1_ff;
                  vol1_in = cur_vol_ff;
                  ph1_in  = cur_ph_ff;
                  if (!have_point) begin
                     seen_in = seen_ff + 2'd1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vol0_ff       <= '0;
         vol1_ff       <= '0;
         ph0_ff        <= '0;
         ph1_ff        <= '0;
         seen_ff       <= '0;
         count_ff      <= '0;
         best_slope_ff <= '0;
         best_vol_ff   <= '0;
         best_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vol0_ff       <= vol0_in;
         vol1_ff       <= vol1_in;
         ph0_ff        <= ph0_in;
         ph1_ff        <= ph1_in;
         seen_ff       <= seen_in;
         count_ff      <= count_in;
         best_slope_ff <= best_slope_in;
         best_vol_ff   <= best_vol_in;
         best_idx_ff   <= best_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_vol_ff  <= cur_vol_in;
      cur_ph_ff   <= cur_ph_in;
      cur_last_ff <= cur_last_in;
      rsp_ff      <= rsp_in;
   end

   assign req_chan.ready = state_ff == ST_IDLE;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.deriv_valid   = rsp_ff.deriv_valid;
   assign rsp_chan.center_volume = rsp_ff.center_volume;
   assign rsp_chan.slope         = rsp_ff.slope;
   assign rsp_chan.spacing_fault = rsp_ff.spacing_fault;
   assign rsp_chan.curve_done    = rsp_ff.curve_done;
   assign rsp_chan.peak_volume   = rsp_ff.peak_volume;
   assign rsp_chan.peak_index    = rsp_ff.peak_index;
   assign rsp_chan.peak_found    = rsp_ff.peak_found;

endmodule

`default_nettype wire

[hw/rtl/nfd_slope_unit.sv]
// ----------------------------------------------------------------------------
// nfd_slope_unit
// Weighted three-point slope: one shared 34x17 multiplier builds numerator
// and denominator in six steps, then a restoring divider gives one quotient
// bit per cycle, with saturation to the signed 32-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module nfd_slope_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   input  wire nfd_pkg::slope_ops_type         ops,
   output logic                                done,
   output logic signed [nfd_pkg::SLOPE_W-1:0]  slope
);

   localparam int QUOT_W = nfd_pkg::SLOPE_W;
   localparam int NUM_W  = 52;
   localparam int DEN_W  = 51;
   localparam int DMAG_W = DEN_W - 1;
   localparam int PH_SHIFT = 12;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_PREP = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   // multiplier schedule
   localparam logic [2:0] M_D10SQ   = 3'd0;
   localparam logic [2:0] M_TIMES21 = 3'd1;
   localparam logic [2:0] M_D21SQ   = 3'd2;
   localparam logic [2:0] M_TIMES10 = 3'd3;
   localparam logic [2:0] M_D10D21  = 3'd4;
   localparam logic [2:0] M_TIMES20 = 3'd5;

   logic [2:0]                   state_ff, state_in;
   logic [4:0]                   cnt_ff, cnt_in;
   nfd_pkg::slope_ops_type       ops_ff, ops_in;
   logic signed [33:0]           t_ff, t_in;
   logic signed [NUM_W-1:0]      num_ff, num_in;
   logic signed [DEN_W-1:0]      den_ff, den_in;
   logic [DMAG_W-1:0]            dmag_ff, dmag_in;
   logic [DMAG_W-1:0]            rem_ff, rem_in;
   logic [QUOT_W-1:0]            lo_ff, lo_in;
   logic                         neg_ff, neg_in;
   logic                         ovf_ff, ovf_in;
   logic                         done_ff, done_in;
   logic signed [QUOT_W-1:0]     slope_ff, slope_in;

   logic signed [33:0]           mul_a;
   logic signed [16:0]           mul_b;
   logic signed [DEN_W-1:0]      prod;
   logic signed [63:0]           num_x;
   logic [63:0]                  num_mag;
   logic [DEN_W-1:0]             den_abs;
   logic [DMAG_W:0]              trial;
   logic [DMAG_W:0]              trial_diff;
   logic                         trial_ge;

   always_comb begin
      mul_a = 34'(ops_ff.d10);
      mul_b = ops_ff.d10;
      case (cnt_ff[2:0])
         M_D10SQ: begin
            mul_a = 34'(ops_ff.d10);
            mul_b = ops_ff.d10;
         end
         M_TIMES21: begin
            mul_a = t_ff;
            mul_b = ops_ff.p21;
         end
         M_D21SQ: begin
            mul_a = 34'(ops_ff.d21);
            mul_b = ops_ff.d21;
         end
         M_TIMES10: begin
            mul_a = t_ff;
            mul_b = ops_ff.p10;
         end
         M_D10D21: begin
            mul_a = 34'(ops_ff.d10);
            mul_b = ops_ff.d21;
         end
         M_TIMES20: begin
            mul_a = t_ff;
            mul_b = ops_ff.d20;
         end
         default: begin
            mul_a = 34'(ops_ff.d10);
            mul_b = ops_ff.d10;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   assign num_x   = {num_ff, {PH_SHIFT{1'b0}}};
   assign num_mag = num_x[63] ? 64'(-num_x) : 64'(num_x);
   assign den_abs = den_ff[DEN_W-1] ? DEN_W'(-den_ff) : DEN_W'(den_ff);

   assign trial      = {rem_ff, lo_ff[QUOT_W-1]};
   assign trial_diff = trial - {1'b0, dmag_ff};
   assign trial_ge   = trial >= {1'b0, dmag_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ops_in   = ops_ff;
      t_in     = t_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      dmag_in  = dmag_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      done_in  = 1'b0;
      slope_in = slope_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ops_in   = ops;
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            case (cnt_ff[2:0])
               M_D10SQ, M_D21SQ, M_D10D21: t_in = prod[33:0];
               M_TIMES21: num_in = NUM_W'(prod);
               M_TIMES10: num_in = num_ff + NUM_W'(prod);
               M_TIMES20: den_in = prod;
               default:   t_in = t_ff;
            endcase
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff[2:0] == M_TIMES20) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            // quotient needs more than 32 bits when the top half already >= den
            neg_in   = num_ff[NUM_W-1] ^ den_ff[DEN_W-1];
            dmag_in  = den_abs[DMAG_W-1:0];
            ovf_in   = DMAG_W'(num_mag[63:32]) >= den_abs[DMAG_W-1:0];
            rem_in   = DMAG_W'(num_mag[63:32]);
            lo_in    = num_mag[31:0];
            cnt_in   = '0;
            state_in = ovf_in ? S_FIN : S_DIV;
         end
         S_DIV: begin
            rem_in = trial_ge ? trial_diff[DMAG_W-1:0] : trial[DMAG_W-1:0];
            lo_in  = {lo_ff[QUOT_W-2:0], trial_ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(QUOT_W - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (ovf_ff) begin
               slope_in = neg_ff ? nfd_pkg::SLOPE_MIN : nfd_pkg::SLOPE_MAX;
            end else if (!neg_ff) begin
               slope_in = lo_ff[QUOT_W-1] ? nfd_pkg::SLOPE_MAX : $signed(lo_ff);
            end else begin
               slope_in = (lo_ff > 32'h8000_0000) ? nfd_pkg::SLOPE_MIN
                                                  : $signed(-lo_ff);
            end
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff   <= cnt_in;
      ops_ff   <= ops_in;
      t_ff     <= t_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      dmag_ff  <= dmag_in;
      rem_ff   <= rem_in;
      lo_ff    <= lo_in;
      neg_ff   <= neg_in;
      ovf_ff   <= ovf_in;
      slope_ff <= slope_in;
   end

   assign done  = done_ff;
   assign slope = slope_ff;

endmodule

`default_nettype wire

[hw/rtl/nfd_checker.sv]
// ----------------------------------------------------------------------------
// nfd_checker
// Port-level checks on the peak finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nfd_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_valid,
   input wire                                req_ready,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire                                rsp_deriv_valid,
   input wire [nfd_pkg::VOL_W-1:0]           rsp_center_volume,
   input wire signed [nfd_pkg::SLOPE_W-1:0]  rsp_slope,
   input wire                                rsp_spacing_fault,
   input wire                                rsp_curve_done,
   input wire [nfd_pkg::VOL_W-1:0]           rsp_peak_volume,
   input wire [nfd_pkg::PEAK_IDX_W-1:0]      rsp_peak_index,
   input wire                                rsp_peak_found
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slope)
         && $stable(rsp_curve_done) && $stable(rsp_center_volume))
      else $error("rsp beat changed while stalled");

   // one sample in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample taken while previous one still in flight");

   a_no_point_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_deriv_valid |-> rsp_slope == '0
         && rsp_center_volume == '0 && !rsp_spacing_fault)
      else $error("point fields set without a derivative point");

   a_peak_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_curve_done |-> !rsp_peak_found
         && rsp_peak_volume == '0 && rsp_peak_index == '0)
      else $error("peak reported before end of curve");

   a_fault_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_spacing_fault |-> rsp_slope == nfd_pkg::SLOPE_MAX
         || rsp_slope == nfd_pkg::SLOPE_MIN)
      else $error("spacing fault without saturated slope");

endmodule

bind nonuniform_derivative_peak_finder nfd_checker u_nfd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_deriv_valid   (rsp_chan.deriv_valid),
   .rsp_center_volume (rsp_chan.center_volume),
   .rsp_slope         (rsp_chan.slope),
   .rsp_spacing_fault (rsp_chan.spacing_fault),
   .rsp_curve_done    (rsp_chan.curve_done),
   .rsp_peak_volume   (rsp_chan.peak_volume),
   .rsp_peak_index    (rsp_chan.peak_index),
   .rsp_peak_found    (rsp_chan.peak_found)
);

`default_nettype wire
